FILE: rtl/core/nlp_pkg.sv
// Shared types and constants for the next-permutation engine.
// No dependencies; every other file in rtl/core except nlp_ram uses this package.
package nlp_pkg;

  // Payload width of the element fields on both channels
  localparam int ValueWidth = 8;

  // Per-result control from the sequencer to the output register
  typedef struct packed {
    logic load;   // load the read data into the output register
    logic last;   // final element of the emitted sequence
    logic wrap;   // sequence wrapped to ascending order
  } nlp_emit_t;

endpackage

FILE: rtl/core/nlp_in_if.sv
// Input channel: one element of the current sequence per item.
// Depends on nlp_pkg for the payload width.
interface nlp_in_if;
  logic                            valid;
  logic                            ready;
  logic [nlp_pkg::ValueWidth-1:0]  element_value;
  logic                            last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

FILE: rtl/core/nlp_out_if.sv
// Output channel: one element of the next permutation per item.
// Depends on nlp_pkg for the payload width.
interface nlp_out_if;
  logic                            valid;
  logic                            ready;
  logic [nlp_pkg::ValueWidth-1:0]  next_value;
  logic                            last_result;
  logic                            wrapped;

  modport source (output valid, output next_value, output last_result, output wrapped,
                  input ready);
  modport sink   (input valid, input next_value, input last_result, input wrapped,
                  output ready);
endinterface

FILE: rtl/core/nlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/nlp_ctrl.sv
// Sequencer: loads the sequence, scans for pivot and swap target with one
// shared comparator, then issues reads in permuted order. Uses nlp_pkg.
module nlp_ctrl #(
  parameter int MAX_ELEMS  = 16,
  parameter int ELEM_WIDTH = 8,
  localparam int AW = $clog2(MAX_ELEMS),
  localparam int CW = $clog2(MAX_ELEMS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_ready,
  input  logic                  out_free,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [AW-1:0]         ram_raddr,
  input  logic [ELEM_WIDTH-1:0] ram_rdata,
  output nlp_pkg::nlp_emit_t    emit
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_PISSUE = 3'd2;
  localparam logic [2:0] S_PCMP   = 3'd3;
  localparam logic [2:0] S_JISSUE = 3'd4;
  localparam logic [2:0] S_JCMP   = 3'd5;
  localparam logic [2:0] S_EISSUE = 3'd6;
  localparam logic [2:0] S_EDATA  = 3'd7;

  logic [2:0]            state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         n, n_next;
  logic [AW-1:0]         ptr, ptr_next;
  logic [AW-1:0]         pivot, pivot_next;
  logic [AW-1:0]         jidx, jidx_next;
  logic [AW-1:0]         k, k_next;
  logic [ELEM_WIDTH-1:0] prev, prev_next;
  logic                  have_prev, have_prev_next;
  logic                  wrap, wrap_next;
  logic                  echo, echo_next;

  logic                  room;
  logic [ELEM_WIDTH-1:0] cmp_a, cmp_b;
  logic                  lt;
  logic [CW:0]           rev_idx;
  logic [AW-1:0]         src;
  logic                  k_last;

  assign room = count < CW'(MAX_ELEMS);

  // Shared comparator: pivot scan tests rdata < prev, target scan prev < rdata
  always_comb begin
    if (state == S_JCMP) begin
      cmp_a = prev;
      cmp_b = ram_rdata;
    end else begin
      cmp_a = ram_rdata;
      cmp_b = prev;
    end
  end
  assign lt = cmp_a < cmp_b;

  // Mirrored index within the reversed range
  always_comb begin
    if (wrap) begin
      rev_idx = {1'b0, n} - (CW+1)'(k) - (CW+1)'(1);
    end else begin
      rev_idx = {1'b0, n} + (CW+1)'(pivot) - (CW+1)'(k);
    end
  end
  assign src    = rev_idx[AW-1:0];
  assign k_last = CW'(k) == (n - CW'(1));

  always_comb begin
    if (state != S_EISSUE) begin
      ram_raddr = ptr;
    end else if (echo) begin
      ram_raddr = k;
    end else if (wrap) begin
      ram_raddr = src;
    end else if (k < pivot) begin
      ram_raddr = k;
    end else if (k == pivot) begin
      ram_raddr = jidx;
    end else if (src == jidx) begin
      ram_raddr = pivot;
    end else begin
      ram_raddr = src;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    n_next         = n;
    ptr_next       = ptr;
    pivot_next     = pivot;
    jidx_next      = jidx;
    k_next         = k;
    prev_next      = prev;
    have_prev_next = have_prev;
    wrap_next      = wrap;
    echo_next      = echo;
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = count[AW-1:0];
    emit           = '0;

    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // drop the element when the store is full
          ram_we = room;
          if (room) begin
            count_next = count + CW'(1);
          end
          if (in_last) begin
            n_next     = room ? count + CW'(1) : count;
            count_next = '0;
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        k_next         = '0;
        wrap_next      = 1'b0;
        have_prev_next = 1'b0;
        ptr_next       = AW'(n - CW'(1));
        if (n < CW'(2)) begin
          echo_next  = 1'b1;
          state_next = S_EISSUE;
        end else begin
          echo_next  = 1'b0;
          state_next = S_PISSUE;
        end
      end
      S_PISSUE: begin
        state_next = S_PCMP;
      end
      S_PCMP: begin
        prev_next      = ram_rdata;
        have_prev_next = 1'b1;
        if (have_prev && lt) begin
          pivot_next = ptr;
          ptr_next   = AW'(n - CW'(1));
          state_next = S_JISSUE;
        end else if (ptr == '0) begin
          // no ascent: reverse the whole sequence
          wrap_next  = 1'b1;
          state_next = S_EISSUE;
        end else begin
          ptr_next   = ptr - AW'(1);
          state_next = S_PISSUE;
        end
      end
      S_JISSUE: begin
        state_next = S_JCMP;
      end
      S_JCMP: begin
        if (lt) begin
          jidx_next  = ptr;
          state_next = S_EISSUE;
        end else begin
          ptr_next   = ptr - AW'(1);
          state_next = S_JISSUE;
        end
      end
      S_EISSUE: begin
        if (out_free) begin
          state_next = S_EDATA;
        end
      end
      S_EDATA: begin
        emit.load = 1'b1;
        emit.last = k_last;
        emit.wrap = wrap;
        if (k_last) begin
          state_next = S_LOAD;
        end else begin
          k_next     = k + AW'(1);
          state_next = S_EISSUE;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    n         <= n_next;
    ptr       <= ptr_next;
    pivot     <= pivot_next;
    jidx      <= jidx_next;
    k         <= k_next;
    prev      <= prev_next;
    have_prev <= have_prev_next;
    wrap      <= wrap_next;
    echo      <= echo_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMS))
    else $error("element count beyond store depth");

  a_target_right: assert property (@(posedge clk) disable iff (rst)
    (state == S_JCMP && lt) |-> ptr > pivot)
    else $error("swap target not right of pivot");

  a_read_before_load: assert property (@(posedge clk) disable iff (rst)
    emit.load |-> $past(state) == S_EISSUE)
    else $error("output load without a prior read");

endmodule

FILE: rtl/core/next_lexicographic_permutation.sv
// Next lexicographic permutation engine: top level.
// Channel din (sink) takes one element per item; last_element closes the
// sequence. Channel dout (source) returns the next permutation, one element
// per item, last_result on the final one, wrapped on every item when the
// input was the greatest permutation and the output is ascending order.
// Valid/ready on both sides; an item moves when both are high.
// din stays ready while a sequence loads. After the closing item of an
// n-element sequence the block passes a setup state, a pivot scan of up to
// n elements, a swap-target scan (each step an issue then a compare state),
// then an issue and a data state per result, all set by the single read
// port of the element store. din is not ready from the
// closing item until the final result has been loaded into the output
// register. A stalled receiver holds the output register and the sequencer
// waits. Synchronous reset empties the output register and the element
// count; store contents are not cleared. Elements beyond MAX_ELEMS are dropped.
// Depends on nlp_pkg, nlp_in_if, nlp_out_if, nlp_ram, nlp_ctrl.
module next_lexicographic_permutation #(
  parameter int MAX_ELEMS  = 16,
  parameter int ELEM_WIDTH = 8
) (
  input logic        clk,
  input logic        rst,
  nlp_in_if.sink     din,
  nlp_out_if.source  dout
);

  localparam int AW = $clog2(MAX_ELEMS);

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic [ELEM_WIDTH-1:0] ram_rdata;
  logic                  out_free;
  logic                  ovalid;
  nlp_pkg::nlp_emit_t    emit;

  // keep only the low ELEM_WIDTH bits of the element
  assign ram_wdata = ELEM_WIDTH'(din.element_value);

  nlp_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (MAX_ELEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nlp_ctrl #(
    .MAX_ELEMS  (MAX_ELEMS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_last   (din.last_element),
    .in_ready  (din.ready),
    .out_free  (out_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .emit      (emit)
  );

  // register is free next cycle if empty now or being taken now
  assign out_free   = !ovalid || dout.ready;
  assign dout.valid = ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit.load) begin
      ovalid <= 1'b1;
    end else if (dout.ready) begin
      ovalid <= 1'b0;
    end
    if (emit.load) begin
      dout.next_value  <= nlp_pkg::ValueWidth'(ram_rdata);
      dout.last_result <= emit.last;
      dout.wrapped     <= emit.wrap;
    end
  end

endmodule
